### rtl/core/alist_pkg.sv
`default_nettype none

package alist_pkg;

   localparam int CAPACITY = 64;

   // fixed field widths of the request and response items
   localparam int OPCODE_W = 3;
   localparam int POS_W    = 6;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int SIZE_W   = 7;

   // storage widths follow the capacity
   localparam int ADDR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int COUNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W   = (POS_W > COUNT_W) ? POS_W : COUNT_W;

   typedef logic [ADDR_W-1:0]   addr_type;
   typedef logic [COUNT_W-1:0]  count_type;
   typedef logic [DATA_W-1:0]   word_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [OPCODE_W-1:0] opcode_type;

   localparam opcode_type OP_APPEND = 3'd0;
   localparam opcode_type OP_INSERT = 3'd1;
   localparam opcode_type OP_DELETE = 3'd2;
   localparam opcode_type OP_FIND   = 3'd3;
   localparam opcode_type OP_GET    = 3'd4;

   localparam status_type ST_OK       = 2'd0;
   localparam status_type ST_RANGE    = 2'd1;
   localparam status_type ST_NOTFOUND = 2'd2;
   localparam status_type ST_FULL     = 2'd3;

endpackage

`default_nettype wire

### rtl/core/alist_ram.sv
`default_nettype none

module alist_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

### rtl/core/bounded_integer_array_list_core.sv
`default_nettype none
// path from the accept to rsp_valid: append, rejected and unused opcodes, delete of the last
//   entry and find on an empty list go straight to the finish state; get reads its entry first;
//   find walks up to the first match or the end; insert and delete shift the entries in between
// throughput: one item at a time, req_ready returns in the cycle rsp_valid rises once the
//   output register is free; the walk over the store, one entry a cycle, sets the pace
// reset: synchronous, clears the element count and the handshake state, not the store

module bounded_integer_array_list_core (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic        [alist_pkg::OPCODE_W-1:0]  req_opcode,
   input  wire logic        [alist_pkg::POS_W-1:0]     req_position,
   input  wire logic signed [alist_pkg::DATA_W-1:0]    req_value,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic             [alist_pkg::STATUS_W-1:0]  rsp_status,
   output logic signed      [alist_pkg::DATA_W-1:0]    rsp_data,
   output logic             [alist_pkg::SIZE_W-1:0]    rsp_size
);

   // sequencer states
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_GET      = 4'd1;
   localparam logic [3:0] S_FIND     = 4'd2;
   localparam logic [3:0] S_INS      = 4'd3;
   localparam logic [3:0] S_INS_LAST = 4'd4;
   localparam logic [3:0] S_INS_PUT  = 4'd5;
   localparam logic [3:0] S_DEL      = 4'd6;
   localparam logic [3:0] S_DEL_LAST = 4'd7;
   localparam logic [3:0] S_FINISH   = 4'd8;

   logic [3:0] state_ff, state_in;

   alist_pkg::count_type  count_ff, count_in;
   alist_pkg::addr_type   idx_ff, idx_in;        // walking address of the store
   alist_pkg::addr_type   pos_ff, pos_in;        // held request position
   alist_pkg::word_type   val_ff, val_in;        // held request value
   logic                  pend_vld_ff, pend_vld_in; // shift write waiting on read data
   alist_pkg::addr_type   pend_addr_ff, pend_addr_in;
   logic                  cmp_vld_ff, cmp_vld_in;    // find compare stage has data
   alist_pkg::addr_type   cmp_idx_ff, cmp_idx_in;
   alist_pkg::status_type res_status_ff, res_status_in;
   alist_pkg::word_type   res_data_ff, res_data_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   alist_pkg::status_type rsp_status_ff, rsp_status_in;
   alist_pkg::word_type   rsp_data_ff, rsp_data_in;
   logic [alist_pkg::SIZE_W-1:0] rsp_size_ff, rsp_size_in;

   // store port
   logic                mem_we;
   alist_pkg::addr_type mem_wr_addr;
   alist_pkg::word_type mem_wr_data;
   alist_pkg::addr_type mem_rd_addr;
   alist_pkg::word_type mem_rd_data;

   logic                          req_fire;
   logic                          out_free;
   logic [alist_pkg::CMP_W-1:0]   pos_ext;
   logic [alist_pkg::CMP_W-1:0]   cnt_ext;
   logic                          pos_bad;
   logic                          list_full;
   alist_pkg::count_type          count_m1;

   alist_ram #(
      .WIDTH (alist_pkg::DATA_W),
      .DEPTH (alist_pkg::CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign pos_ext   = alist_pkg::CMP_W'(req_position);
   assign cnt_ext   = alist_pkg::CMP_W'(count_ff);
   assign pos_bad   = (pos_ext >= cnt_ext);
   assign list_full = (count_ff == alist_pkg::COUNT_W'(alist_pkg::CAPACITY));
   assign count_m1  = count_ff - alist_pkg::COUNT_W'(1);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      pend_vld_in   = pend_vld_ff;
      pend_addr_in  = pend_addr_ff;
      cmp_vld_in    = cmp_vld_ff;
      cmp_idx_in    = cmp_idx_ff;
      res_status_in = res_status_ff;
      res_data_in   = res_data_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_size_in   = rsp_size_ff;

      mem_we      = 1'b0;
      mem_wr_addr = pend_addr_ff;
      mem_wr_data = mem_rd_data;
      mem_rd_addr = idx_ff;

      // output register drains independently of the sequencer
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            // get reads its entry straight from the request position
            mem_rd_addr = alist_pkg::ADDR_W'(req_position);
            if (req_fire) begin
               pos_in        = alist_pkg::ADDR_W'(req_position);
               val_in        = req_value;
               res_status_in = alist_pkg::ST_OK;
               res_data_in   = '0;
               pend_vld_in   = 1'b0;
               cmp_vld_in    = 1'b0;
               state_in      = S_FINISH;
               unique case (req_opcode)
                  alist_pkg::OP_APPEND: begin
                     if (list_full) begin
                        res_status_in = alist_pkg::ST_FULL;
                     end else begin
                        mem_we      = 1'b1;
                        mem_wr_addr = alist_pkg::ADDR_W'(count_ff);
                        mem_wr_data = req_value;
                        count_in    = count_ff + alist_pkg::COUNT_W'(1);
                     end
                  end
                  alist_pkg::OP_INSERT: begin
                     if (pos_bad) begin
                        res_status_in = alist_pkg::ST_RANGE;
                     end else if (list_full) begin
                        res_status_in = alist_pkg::ST_FULL;
                     end else begin
                        // shift from the top entry down to the position
                        idx_in   = alist_pkg::ADDR_W'(count_m1);
                        state_in = S_INS;
                     end
                  end
                  alist_pkg::OP_DELETE: begin
                     if (pos_bad) begin
                        res_status_in = alist_pkg::ST_RANGE;
                     end else if (pos_ext + alist_pkg::CMP_W'(1) == cnt_ext) begin
                        // last entry: nothing to move
                        count_in = count_m1;
                     end else begin
                        idx_in   = alist_pkg::ADDR_W'(req_position) + alist_pkg::ADDR_W'(1);
                        state_in = S_DEL;
                     end
                  end
                  alist_pkg::OP_FIND: begin
                     if (count_ff == '0) begin
                        res_status_in = alist_pkg::ST_NOTFOUND;
                     end else begin
                        idx_in   = '0;
                        state_in = S_FIND;
                     end
                  end
                  alist_pkg::OP_GET: begin
                     if (pos_bad) begin
                        res_status_in = alist_pkg::ST_RANGE;
                     end else begin
                        state_in = S_GET;
                     end
                  end
                  default: begin
                     // unused opcode: no change, ok with zero data
                  end
               endcase
            end
         end

         S_GET: begin
            res_data_in = mem_rd_data;
            state_in    = S_FINISH;
         end

         S_FIND: begin
            // read one entry a cycle, compare the previous one
            mem_rd_addr = idx_ff;
            idx_in      = idx_ff + alist_pkg::ADDR_W'(1);
            cmp_vld_in  = 1'b1;
            cmp_idx_in  = idx_ff;
            if (cmp_vld_ff) begin
               if (mem_rd_data == val_ff) begin
                  res_data_in = alist_pkg::DATA_W'(cmp_idx_ff);
                  state_in    = S_FINISH;
               end else if (alist_pkg::COUNT_W'(cmp_idx_ff) + alist_pkg::COUNT_W'(1)
                            == count_ff) begin
                  res_status_in = alist_pkg::ST_NOTFOUND;
                  state_in      = S_FINISH;
               end
            end
         end

         S_INS: begin
            // read entry i, write it to i + 1 in the next cycle
            mem_rd_addr  = idx_ff;
            mem_we       = pend_vld_ff;
            pend_vld_in  = 1'b1;
            pend_addr_in = idx_ff + alist_pkg::ADDR_W'(1);
            if (idx_ff == pos_ff) begin
               state_in = S_INS_LAST;
            end else begin
               idx_in = idx_ff - alist_pkg::ADDR_W'(1);
            end
         end

         S_INS_LAST: begin
            mem_we   = 1'b1;
            state_in = S_INS_PUT;
         end

         S_INS_PUT: begin
            mem_we      = 1'b1;
            mem_wr_addr = pos_ff;
            mem_wr_data = val_ff;
            count_in    = count_ff + alist_pkg::COUNT_W'(1);
            state_in    = S_FINISH;
         end

         S_DEL: begin
            // read entry i, write it to i - 1 in the next cycle
            mem_rd_addr  = idx_ff;
            mem_we       = pend_vld_ff;
            pend_vld_in  = 1'b1;
            pend_addr_in = idx_ff - alist_pkg::ADDR_W'(1);
            if (alist_pkg::COUNT_W'(idx_ff) + alist_pkg::COUNT_W'(1) == count_ff) begin
               state_in = S_DEL_LAST;
            end else begin
               idx_in = idx_ff + alist_pkg::ADDR_W'(1);
            end
         end

         S_DEL_LAST: begin
            mem_we   = 1'b1;
            count_in = count_m1;
            state_in = S_FINISH;
         end

         S_FINISH: begin
            // hand the result over once the output register is free
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_data_in   = res_data_ff;
               rsp_size_in   = alist_pkg::SIZE_W'(count_ff);
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pend_vld_ff  <= 1'b0;
         cmp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_vld_ff  <= pend_vld_in;
         cmp_vld_ff   <= cmp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      pend_addr_ff  <= pend_addr_in;
      cmp_idx_ff    <= cmp_idx_in;
      res_status_ff <= res_status_in;
      res_data_ff   <= res_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_size_ff   <= rsp_size_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_data   = $signed(rsp_data_ff);
   assign rsp_size   = rsp_size_ff;

   // count never passes the capacity
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= alist_pkg::COUNT_W'(alist_pkg::CAPACITY))
      else $error("element count above capacity");

   // count moves by at most one per item
   assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> (count_ff == $past(count_ff)
         || count_ff == $past(count_ff) + alist_pkg::COUNT_W'(1)
         || count_ff == $past(count_ff) - alist_pkg::COUNT_W'(1)))
      else $error("element count jumped");

   // an accepted item always leaves idle, so only one is in flight
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("second item taken while busy");

   // lookups never write the store
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIND || state_ff == S_GET) |-> !mem_we)
      else $error("store written during lookup");

endmodule

`default_nettype wire
